/* rtl/com_pkg.sv */
package com_pkg;

  localparam int CMD_W     = 2;
  localparam int CHAN_W    = 5;
  localparam int RSSI_W    = 8;
  localparam int MASK_W    = 32;
  localparam int OCC_W     = 16;
  localparam int WIN_W     = 13;
  localparam int PASS_W    = 16;
  localparam int NUM_W     = OCC_W + WIN_W;
  localparam int DIV_CNT_W = $clog2(OCC_W);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = WIN_W;

  localparam logic [OCC_W-1:0]         OCC_FULL      = '1;
  localparam logic [PASS_W-1:0]        PASS_MAX      = '1;
  localparam logic signed [RSSI_W-1:0] RSSI_INVALID  = 8'sd127;
  localparam logic signed [RSSI_W-1:0] THRESH_RESET  = -8'sd75;
  localparam logic [WIN_W-1:0]         WINDOW_RESET  = 13'd960;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_PASS   = 2'd1,
    CMD_BEST   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_WINDOW    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic scan_step;
    logic out_load;
  } com_cmd_t;

  typedef struct packed {
    logic chan_ok;
    logic div_last;
    logic scan_last;
  } com_status_t;

endpackage

/* rtl/channel_occupancy_monitor.sv */
// A sample on a valid channel goes through a multiply step and the 16-step restoring divider;
// find best walks over all 32 channel numbers, one per cycle; pass end, clear and a bad-channel
// sample go straight to the output load, which waits for a free output register.
// One item is in work at a time; a new item is taken only while the block is idle.
// Reset is synchronous and active low; it zeroes the averages, group index and pass count
// and loads the threshold with -75 and the window with 960.
module channel_occupancy_monitor #(
  parameter int NUM_CHANNELS  = 16,
  parameter int NUM_GROUPS    = 4,
  parameter int FIRST_CHANNEL = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [com_pkg::CMD_W-1:0]           in_command,
  input  logic [com_pkg::CHAN_W-1:0]          in_channel,
  input  logic signed [com_pkg::RSSI_W-1:0]   in_rssi,
  input  logic [com_pkg::MASK_W-1:0]          in_channel_mask,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [com_pkg::MASK_W-1:0]          out_scan_mask,
  output logic [com_pkg::MASK_W-1:0]          out_best_mask,
  output logic [com_pkg::OCC_W-1:0]           out_best_occupancy,
  output logic [com_pkg::PASS_W-1:0]          out_pass_count,
  output logic                                out_bad_channel,
  input  logic                                cfg_we,
  input  logic [com_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [com_pkg::CFG_W-1:0]           cfg_wdata
);

  com_pkg::com_cmd_t    cmd;
  com_pkg::com_status_t status;

  com_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status)
  );

  com_dp #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .NUM_GROUPS    (NUM_GROUPS),
    .FIRST_CHANNEL (FIRST_CHANNEL)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_channel         (in_channel),
    .in_rssi            (in_rssi),
    .in_channel_mask    (in_channel_mask),
    .out_scan_mask      (out_scan_mask),
    .out_best_mask      (out_best_mask),
    .out_best_occupancy (out_best_occupancy),
    .out_pass_count     (out_pass_count),
    .out_bad_channel    (out_bad_channel),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .status             (status)
  );

endmodule

/* rtl/com_ctrl.sv */
module com_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [com_pkg::CMD_W-1:0]   in_command,
  output logic                        out_valid,
  input  logic                        out_ready,
  output com_pkg::com_cmd_t           cmd,
  input  com_pkg::com_status_t        status
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_command) inside
            com_pkg::CMD_SAMPLE: state_nxt = status.chan_ok ? S_MUL : S_FIN;
            com_pkg::CMD_BEST:   state_nxt = S_SCAN;
            com_pkg::CMD_PASS, com_pkg::CMD_CLEAR: state_nxt = S_FIN;
            default:             state_nxt = S_FIN;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/com_dp.sv */
module com_dp #(
  parameter int NUM_CHANNELS  = 16,
  parameter int NUM_GROUPS    = 4,
  parameter int FIRST_CHANNEL = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [com_pkg::CMD_W-1:0]           in_command,
  input  logic [com_pkg::CHAN_W-1:0]          in_channel,
  input  logic signed [com_pkg::RSSI_W-1:0]   in_rssi,
  input  logic [com_pkg::MASK_W-1:0]          in_channel_mask,
  output logic [com_pkg::MASK_W-1:0]          out_scan_mask,
  output logic [com_pkg::MASK_W-1:0]          out_best_mask,
  output logic [com_pkg::OCC_W-1:0]           out_best_occupancy,
  output logic [com_pkg::PASS_W-1:0]          out_pass_count,
  output logic                                out_bad_channel,
  input  logic                                cfg_we,
  input  logic [com_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [com_pkg::CFG_W-1:0]           cfg_wdata,
  input  com_pkg::com_cmd_t                   cmd,
  output com_pkg::com_status_t                status
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int GRP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CW    = com_pkg::CHAN_W;
  localparam int OW    = com_pkg::OCC_W;
  localparam int WW    = com_pkg::WIN_W;
  localparam int PW    = com_pkg::PASS_W;
  localparam int NW    = com_pkg::NUM_W;

  function automatic logic chan_ok(input logic [CW-1:0] c);
    chan_ok = ({1'b0, c} >= (CW+1)'(FIRST_CHANNEL)) &&
              ({1'b0, c} <  (CW+1)'(FIRST_CHANNEL + NUM_CHANNELS));
  endfunction

  function automatic logic [IDX_W-1:0] chan_idx(input logic [CW-1:0] c);
    logic [CW:0] d;
    d = {1'b0, c} - (CW+1)'(FIRST_CHANNEL);
    chan_idx = d[IDX_W-1:0];
  endfunction

  logic signed [com_pkg::RSSI_W-1:0] thresh_r;
  logic [WW-1:0]                     window_r;
  logic [OW-1:0]                     occ_r [NUM_CHANNELS];
  logic [GRP_W-1:0]                  grp_r;
  logic [PW-1:0]                     pass_r;

  logic [CW-1:0]                     chan_r;
  logic                              busy_r;
  logic                              bad_r;
  logic [com_pkg::MASK_W-1:0]        mask_r;
  logic [com_pkg::MASK_W-1:0]        best_r;
  logic [OW-1:0]                     min_r;
  logic [CW-1:0]                     scan_cnt_r;
  logic [WW-1:0]                     rem_r;
  logic [OW-1:0]                     low_r;
  logic [WW-1:0]                     dvs_r;
  logic [com_pkg::DIV_CNT_W-1:0]     div_cnt_r;

  logic [CW-1:0]                     rd_chan;
  logic                              rd_ok;
  logic [OW-1:0]                     rd_occ;
  logic [WW-1:0]                     win_m1;
  logic [WW-1:0]                     weight;
  logic [NW-1:0]                     num;
  logic [WW:0]                       trial;
  logic                              qbit;
  logic [WW-1:0]                     rem_nxt;
  logic [OW-1:0]                     low_nxt;
  logic [com_pkg::MASK_W-1:0]        scan_mask_c;
  logic                              in_busy;

  assign rd_chan = cmd.scan_step ? scan_cnt_r : chan_r;
  assign rd_ok   = chan_ok(rd_chan);
  assign rd_occ  = rd_ok ? occ_r[chan_idx(rd_chan)] : '0;

  assign win_m1 = (window_r == '0) ? '0 : window_r - WW'(1);
  assign weight = (pass_r < {{(PW-WW){1'b0}}, win_m1}) ? pass_r[WW-1:0] : win_m1;
  assign num    = NW'(rd_occ) * NW'(weight) + NW'(busy_r ? com_pkg::OCC_FULL : '0);

  assign trial   = {rem_r, low_r[OW-1]};
  assign qbit    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = qbit ? WW'(trial - {1'b0, dvs_r}) : trial[WW-1:0];
  assign low_nxt = {low_r[OW-2:0], qbit};

  assign in_busy = (in_rssi != com_pkg::RSSI_INVALID) && (in_rssi >= thresh_r);

  assign status.chan_ok   = chan_ok(in_channel);
  assign status.div_last  = (div_cnt_r == com_pkg::DIV_CNT_W'(OW - 1));
  assign status.scan_last = (scan_cnt_r == '1);

  always_comb begin
    scan_mask_c = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if ((GRP_W'(k % NUM_GROUPS) == grp_r) && (FIRST_CHANNEL + k < com_pkg::MASK_W)) begin
        scan_mask_c[CW'(FIRST_CHANNEL + k)] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= com_pkg::THRESH_RESET;
      window_r <= com_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        com_pkg::REG_THRESHOLD: thresh_r <= cfg_wdata[com_pkg::RSSI_W-1:0];
        com_pkg::REG_WINDOW:    window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r  <= '0;
      pass_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        occ_r[i] <= '0;
      end
    end else begin
      if (cmd.accept && (in_command == com_pkg::CMD_CLEAR)) begin
        grp_r  <= '0;
        pass_r <= '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          occ_r[i] <= '0;
        end
      end else if (cmd.accept && (in_command == com_pkg::CMD_PASS)) begin
        if (grp_r == GRP_W'(NUM_GROUPS - 1)) begin
          grp_r <= '0;
          if (pass_r != com_pkg::PASS_MAX) begin
            pass_r <= pass_r + PW'(1);
          end
        end else begin
          grp_r <= grp_r + GRP_W'(1);
        end
      end
      if (cmd.div_step && status.div_last) begin
        occ_r[chan_idx(chan_r)] <= low_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chan_r     <= in_channel;
      busy_r     <= in_busy;
      bad_r      <= (in_command == com_pkg::CMD_SAMPLE) && !status.chan_ok;
      mask_r     <= in_channel_mask;
      best_r     <= '0;
      min_r      <= (in_command == com_pkg::CMD_BEST) ? com_pkg::OCC_FULL : '0;
      scan_cnt_r <= '0;
    end
    if (cmd.mul) begin
      rem_r     <= num[NW-1:OW];
      low_r     <= num[OW-1:0];
      dvs_r     <= weight + WW'(1);
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      low_r     <= low_nxt;
      div_cnt_r <= div_cnt_r + com_pkg::DIV_CNT_W'(1);
    end
    if (cmd.scan_step) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
      if (mask_r[scan_cnt_r] && (rd_occ <= min_r)) begin
        if (rd_occ < min_r) begin
          best_r <= com_pkg::MASK_W'(1) << scan_cnt_r;
        end else begin
          best_r <= best_r | (com_pkg::MASK_W'(1) << scan_cnt_r);
        end
        min_r <= rd_occ;
      end
    end
    if (cmd.out_load) begin
      out_scan_mask      <= scan_mask_c;
      out_best_mask      <= best_r;
      out_best_occupancy <= min_r;
      out_pass_count     <= pass_r;
      out_bad_channel    <= bad_r;
    end
  end

endmodule
